@@ design/timed_task_dispatch_queue_assert.svh @@
// Assertion macros shared by the dispatch queue modules.
// Depends on nothing; included inside module bodies.
`ifndef TIMED_TASK_DISPATCH_QUEUE_ASSERT_SVH
`define TIMED_TASK_DISPATCH_QUEUE_ASSERT_SVH
// Check that holds every cycle outside reset.
`define TTDQ_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ttdq check failed");
// Implication; consequent checked the next cycle.
`define TTDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttdq check failed");
`endif

@@ design/ttdq_pkg.sv @@
// Package for the timed task dispatch queue: codes, widths, defaults.
// No dependencies.
package ttdq_pkg;
    localparam int DEF_DEFERRED_DEPTH = 16;
    localparam int DEF_IRQ_DEPTH      = 8;
    localparam int DEF_ASAP_DEPTH     = 16;
    localparam int DEF_TIME_WIDTH     = 32;
    localparam int DEF_TASK_ID_WIDTH  = 8;

    localparam int OUT_TASK_W = 8;
    localparam int IN_TIME_W  = 32;

    typedef enum logic [2:0] {
        OP_DISPATCH = 3'd0,
        OP_ASAP     = 3'd1,
        OP_IRQ      = 3'd2,
        OP_DEF_AT   = 3'd3,
        OP_DEF_FOR  = 3'd4,
        OP_REMOVE   = 3'd5,
        OP_PEEK     = 3'd6,
        OP_CLEAR    = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        SRC_NONE  = 3'd0,
        SRC_IRQ   = 3'd1,
        SRC_DEFER = 3'd2,
        SRC_ASAP  = 3'd3,
        SRC_IDLE  = 3'd4
    } t_source;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic CFG_IDLE_TASK   = 1'b0;
    localparam logic CFG_IDLE_ENABLE = 1'b1;

    // Command broadcast to every cell of the deferred chain.
    typedef struct packed {
        logic ins;   // insert the new entry
        logic pop;   // drop the earliest entry
        logic rem;   // compact out matching task ids
        logic clr;   // empty the chain
    } t_cell_cmd;
endpackage

@@ design/timed_task_dispatch_queue.sv @@
// Timed task dispatch queue: irq FIFO, ASAP FIFO and a time-sorted deferred
// cell chain. A result shows in the cycle after its transaction is taken;
// one transaction per cycle when the output is drained. Every cell compares
// and shifts in the same cycle, so depth does not change the rate.
// Synchronous active-low reset empties all stores; idle task cleared.
module timed_task_dispatch_queue #(
    parameter int DEFERRED_DEPTH = ttdq_pkg::DEF_DEFERRED_DEPTH,
    parameter int IRQ_DEPTH      = ttdq_pkg::DEF_IRQ_DEPTH,
    parameter int ASAP_DEPTH     = ttdq_pkg::DEF_ASAP_DEPTH,
    parameter int TIME_WIDTH     = ttdq_pkg::DEF_TIME_WIDTH,
    parameter int TASK_ID_WIDTH  = ttdq_pkg::DEF_TASK_ID_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_task_id,
    input  logic [ttdq_pkg::IN_TIME_W-1:0] i_time_value,
    input  logic [ttdq_pkg::IN_TIME_W-1:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_task,
    output logic        o_task_valid,
    output logic [2:0]  o_source,
    output logic [1:0]  o_status,
    output logic [4:0]  o_deferred_count
);
    import ttdq_pkg::*;
    localparam int TW = TASK_ID_WIDTH;
    localparam int CW = $clog2(DEFERRED_DEPTH + 1);

    logic [7:0]          r_idle_task;
    logic                r_idle_en;
    logic                accept;
    t_opcode             op;
    logic [TW-1:0]       task_in;
    logic [TIME_WIDTH-1:0] tval, now, due;
    logic                irq_empty, irq_full, asap_empty, asap_full;
    logic [TW-1:0]       irq_head, asap_head, def_head;
    logic                def_full, def_empty, def_due, def_found;
    logic [CW-1:0]       def_count;
    t_cell_cmd           cmd;
    logic                irq_push, irq_pop, asap_push, asap_pop;
    logic                r_ovalid;
    logic [7:0]          r_task, n_task;
    logic                r_tv, n_tv;
    t_source             r_src, n_src;
    t_status             r_st, n_st;
    logic [4:0]          r_cnt;

    assign o_stall = r_ovalid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign op      = t_opcode'(i_opcode);
    assign task_in = TW'(i_task_id);
    assign tval    = TIME_WIDTH'(i_time_value);
    assign now     = TIME_WIDTH'(i_now_time);
    assign due     = (op == OP_DEF_FOR) ? now + tval : tval;

    always_comb begin
        cmd       = '0;
        irq_push  = 1'b0;
        irq_pop   = 1'b0;
        asap_push = 1'b0;
        asap_pop  = 1'b0;
        n_task    = '0;
        n_tv      = 1'b0;
        n_src     = SRC_NONE;
        n_st      = ST_OK;
        unique case (op)
            OP_DISPATCH: begin
                if (!irq_empty) begin
                    irq_pop = accept;
                    n_task = 8'(irq_head); n_tv = 1'b1; n_src = SRC_IRQ;
                end else if (def_due) begin
                    cmd.pop = accept;
                    n_task = 8'(def_head); n_tv = 1'b1; n_src = SRC_DEFER;
                end else if (!asap_empty) begin
                    asap_pop = accept;
                    n_task = 8'(asap_head); n_tv = 1'b1; n_src = SRC_ASAP;
                end else if (r_idle_en) begin
                    n_task = r_idle_task; n_tv = 1'b1; n_src = SRC_IDLE;
                end
            end
            OP_ASAP: begin
                if (asap_full) n_st = ST_FULL;
                else asap_push = accept;
            end
            OP_IRQ: begin
                if (irq_full) n_st = ST_FULL;
                else irq_push = accept;
            end
            OP_DEF_AT, OP_DEF_FOR: begin
                if (def_full) n_st = ST_FULL;
                else cmd.ins = accept;
            end
            OP_REMOVE: begin
                cmd.rem = accept;
                if (!def_found) n_st = ST_NOT_FOUND;
            end
            OP_PEEK: begin
                if (!def_empty) begin
                    n_task = 8'(def_head); n_tv = 1'b1; n_src = SRC_DEFER;
                end else if (!asap_empty) begin
                    n_task = 8'(asap_head); n_tv = 1'b1; n_src = SRC_ASAP;
                end
            end
            OP_CLEAR: cmd.clr = accept;
            default: ;
        endcase
    end

    ttdq_fifo #(.DEPTH(IRQ_DEPTH), .TW(TW)) u_irq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(irq_push), .i_pop(irq_pop),
        .i_data(task_in), .o_head(irq_head), .o_empty(irq_empty), .o_full(irq_full)
    );

    ttdq_fifo #(.DEPTH(ASAP_DEPTH), .TW(TW)) u_asap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(asap_push), .i_pop(asap_pop),
        .i_data(task_in), .o_head(asap_head), .o_empty(asap_empty), .o_full(asap_full)
    );

    ttdq_chain #(.DEPTH(DEFERRED_DEPTH), .TIME_W(TIME_WIDTH), .TW(TW)) u_chain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_time(due),
        .i_task(task_in), .i_now(now), .o_full(def_full), .o_empty(def_empty),
        .o_due(def_due), .o_found(def_found), .o_head_task(def_head),
        .o_count(def_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_task <= '0;
            r_idle_en   <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDLE_TASK) r_idle_task <= i_cfg_data;
            else r_idle_en <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task <= n_task;
            r_tv   <= n_tv;
            r_src  <= n_src;
            r_st   <= n_st;
            r_cnt  <= 5'(def_count);
        end
    end

    assign o_valid          = r_ovalid;
    assign o_out_task       = r_task;
    assign o_task_valid     = r_tv;
    assign o_source         = r_src;
    assign o_status         = r_st;
    assign o_deferred_count = r_cnt;
endmodule

@@ design/ttdq_fifo.sv @@
// Circular task-id FIFO with a registered count, used for the irq and ASAP stores.
// Depends on ttdq_pkg.
module ttdq_fifo #(
    parameter int DEPTH = 8,
    parameter int TW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  logic [TW-1:0] i_data,
    output logic [TW-1:0] o_head,
    output logic          o_empty,
    output logic          o_full
);
    import ttdq_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] cnt_up, cnt_dn;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_head];
    assign cnt_up  = r_count + CW'(1);
    assign cnt_dn  = r_count - CW'(1);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        n_head  = do_pop ? wrap_inc(r_head) : r_head;
        n_tail  = do_push ? wrap_inc(r_tail) : r_tail;
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

`include "timed_task_dispatch_queue_assert.svh"
    `TTDQ_ASSERT(a_fifo_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `TTDQ_ASSERT_NEXT(a_fifo_grow, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(cnt_up))
    `TTDQ_ASSERT_NEXT(a_fifo_shrink, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(cnt_dn))
endmodule

@@ design/ttdq_cell.sv @@
// One slot of the deferred chain: holds a due time and task id, shifts toward
// its neighbors. Depends on ttdq_pkg.
module ttdq_cell #(
    parameter int TIME_W = 32,
    parameter int TW     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttdq_pkg::t_cell_cmd  i_cmd,
    input  logic [TIME_W-1:0]    i_new_time,
    input  logic [TW-1:0]        i_new_task,
    input  logic                 i_below_valid,   // neighbor toward tail (earlier index)
    input  logic [TIME_W-1:0]    i_below_time,
    input  logic [TW-1:0]        i_below_task,
    input  logic                 i_below_after,   // some entry at or above below slot is after
    input  logic                 i_above_valid,   // neighbor toward head
    input  logic                 i_above_after,   // some entry above this slot is after
    input  logic                 i_comp_valid,    // compacted view for remove
    input  logic [TIME_W-1:0]    i_comp_time,
    input  logic [TW-1:0]        i_comp_task,
    output logic                 o_valid,
    output logic [TIME_W-1:0]    o_time,
    output logic [TW-1:0]        o_task,
    output logic                 o_after,         // this or a higher entry after new time
    output logic                 o_keep           // this entry survives a remove
);
    import ttdq_pkg::*;
    logic              r_valid, n_valid;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TW-1:0]     r_task, n_task;
    logic [TIME_W-1:0] diff;
    logic              self_after;

    assign diff       = r_time - i_new_time;
    assign self_after = r_valid && (diff != '0) && !diff[TIME_W-1];
    assign o_after    = self_after || i_above_after;
    assign o_keep     = r_valid && (r_task != i_new_task);
    assign o_valid    = r_valid;
    assign o_time     = r_time;
    assign o_task     = r_task;

    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_task  = r_task;
        if (i_cmd.clr) begin
            n_valid = 1'b0;
        end else if (i_cmd.ins) begin
            // new entry lands just above the highest entry that is after it;
            // everything from there up moves one slot toward the head
            if (!o_after && i_below_after) begin
                n_valid = 1'b1;
                n_time  = i_new_time;
                n_task  = i_new_task;
            end else if (!o_after && i_below_valid) begin
                n_valid = 1'b1;
                n_time  = i_below_time;
                n_task  = i_below_task;
            end
        end else if (i_cmd.pop) begin
            n_valid = r_valid && i_above_valid;
        end else if (i_cmd.rem) begin
            n_valid = i_comp_valid;
            n_time  = i_comp_time;
            n_task  = i_comp_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_task <= n_task;
    end
endmodule

@@ design/ttdq_chain.sv @@
// Deferred queue as a row of cells. Slot 0 is the latest entry, the
// highest valid slot the earliest. Depends on ttdq_pkg and ttdq_cell.
module ttdq_chain #(
    parameter int DEPTH  = 16,
    parameter int TIME_W = 32,
    parameter int TW     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttdq_pkg::t_cell_cmd  i_cmd,
    input  logic [TIME_W-1:0]    i_time,
    input  logic [TW-1:0]        i_task,
    input  logic [TIME_W-1:0]    i_now,
    output logic                 o_full,
    output logic                 o_empty,
    output logic                 o_due,
    output logic                 o_found,
    output logic [TW-1:0]        o_head_task,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import ttdq_pkg::*;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0]  v, aft, kp;
    logic [TIME_W-1:0] tm [DEPTH];
    logic [TW-1:0]     tk [DEPTH];
    logic [DEPTH-1:0]  cmp_v;
    logic [TIME_W-1:0] cmp_t [DEPTH];
    logic [TW-1:0]     cmp_k_task [DEPTH];
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     head_idx;
    logic [TIME_W-1:0] head_time, due_diff;
    t_cell_cmd         cell_cmd;

    // Removal compacts toward slot 0 by skipping matching entries: target slot
    // w gets the w-th surviving entry counting from slot 0.
    always_comb begin
        logic [CW-1:0] w;
        w = '0;
        cmp_v = '0;
        for (int j = 0; j < DEPTH; j++) begin
            cmp_t[j]      = tm[j];
            cmp_k_task[j] = tk[j];
        end
        for (int r = 0; r < DEPTH; r++) begin
            if (kp[r]) begin
                cmp_v[w[AW-1:0]]      = 1'b1;
                cmp_t[w[AW-1:0]]      = tm[r];
                cmp_k_task[w[AW-1:0]] = tk[r];
                w = w + CW'(1);
            end
        end
    end

    // Insert shifts cells; pop clears the top slot; remove uses the compacted view.
    assign cell_cmd = i_cmd;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              bv, ba, av, aa;
        logic [TIME_W-1:0] bt;
        logic [TW-1:0]     bk;
        if (g == 0) begin : g_first
            // nothing below slot 0: it takes the new entry when nothing is after it
            assign bv = 1'b0;
            assign ba = 1'b1;
            assign bt = '0;
            assign bk = '0;
        end else begin : g_rest
            assign bv = v[g-1];
            assign ba = aft[g-1];
            assign bt = tm[g-1];
            assign bk = tk[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign av = 1'b0;
            assign aa = 1'b0;
        end else begin : g_inner
            assign av = v[g+1];
            assign aa = aft[g+1];
        end
        ttdq_cell #(.TIME_W(TIME_W), .TW(TW)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cell_cmd),
            .i_new_time    (i_time),
            .i_new_task    (i_task),
            .i_below_valid (bv),
            .i_below_time  (bt),
            .i_below_task  (bk),
            .i_below_after (ba),
            .i_above_valid (av),
            .i_above_after (aa),
            .i_comp_valid  (cmp_v[g]),
            .i_comp_time   (cmp_t[g]),
            .i_comp_task   (cmp_k_task[g]),
            .o_valid       (v[g]),
            .o_time        (tm[g]),
            .o_task        (tk[g]),
            .o_after       (aft[g]),
            .o_keep        (kp[g])
        );
    end

    assign head_idx    = (r_count == '0) ? '0 : AW'(r_count - CW'(1));
    assign head_time   = tm[head_idx];
    assign o_head_task = tk[head_idx];
    assign due_diff    = i_now - head_time;
    assign o_empty     = (r_count == '0);
    assign o_full      = (r_count == CW'(DEPTH));
    assign o_due       = !o_empty && !due_diff[TIME_W-1];
    assign o_found     = (kp != v);
    assign o_count     = n_count;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr) begin
            n_count = '0;
        end else if (i_cmd.rem) begin
            n_count = CW'($countones(kp));
        end else if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`include "timed_task_dispatch_queue_assert.svh"
    `TTDQ_ASSERT(a_chain_count_match, i_clk, i_rst_n, CW'($countones(v)) == r_count)
    `TTDQ_ASSERT(a_chain_no_overflow, i_clk, i_rst_n, !(i_cmd.ins && o_full))
    `TTDQ_ASSERT_NEXT(a_chain_clear, i_clk, i_rst_n, i_cmd.clr, v == '0)
endmodule

@@ dv/tb_timed_task_dispatch_queue.sv @@
// Testbench for the timed task dispatch queue: drives queue operations over
// valid/stall, predicts each result with a behavioral queue model, checks it.
// Depends on ttdq_pkg and the timed_task_dispatch_queue RTL.
module tb_timed_task_dispatch_queue;
    import ttdq_pkg::*;

    localparam int DDEP = 16;
    localparam int IDEP = 8;
    localparam int ADEP = 16;
    localparam int LIMIT = 5000;

    typedef struct packed {
        logic [7:0] task_id;
        logic       task_valid;
        t_source    source;
        t_status    status;
        logic [4:0] dcount;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_opcode = '0;
    logic [7:0]  i_task_id = '0;
    logic [31:0] i_time_value = '0;
    logic [31:0] i_now_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_task;
    logic        o_task_valid;
    logic [2:0]  o_source;
    logic [1:0]  o_status;
    logic [4:0]  o_deferred_count;

    timed_task_dispatch_queue u_top (.*);

    // predictor state; deferred index used-1 is the earliest entry
    logic [31:0] dq_time[DDEP];
    logic [7:0]  dq_task[DDEP];
    int          dq_used;
    logic [7:0]  irq_q[$];
    logic [7:0]  asap_q[$];
    logic [7:0]  idle_id;
    logic        idle_en;

    t_result expected_results[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      quiet_cycles = 0;
    logic [31:0] clock_now = 32'h0;

    initial forever #4 i_clk = ~i_clk;

    function automatic bit is_after(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic void defer_add(logic [7:0] id, logic [31:0] at, ref t_result r);
        int i;
        if (dq_used >= DDEP) begin
            r.status = ST_FULL;
            return;
        end
        i = dq_used;
        while (i > 0 && !is_after(dq_time[i-1], at)) i--;
        for (int k = dq_used; k > i; k--) begin
            dq_time[k] = dq_time[k-1];
            dq_task[k] = dq_task[k-1];
        end
        dq_time[i] = at;
        dq_task[i] = id;
        dq_used++;
    endfunction

    function automatic t_result predict_dispatch(t_opcode op, logic [7:0] id,
                                                 logic [31:0] tv, logic [31:0] now);
        t_result r;
        int w;
        logic [31:0] d;
        r = '{8'h0, 1'b0, SRC_NONE, ST_OK, 5'd0};
        case (op)
            OP_DISPATCH: begin
                d = now - dq_time[dq_used > 0 ? dq_used-1 : 0];
                if (irq_q.size() > 0) begin
                    r.task_id = irq_q.pop_front(); r.task_valid = 1; r.source = SRC_IRQ;
                end else if (dq_used > 0 && !d[31]) begin
                    dq_used--;
                    r.task_id = dq_task[dq_used]; r.task_valid = 1; r.source = SRC_DEFER;
                end else if (asap_q.size() > 0) begin
                    r.task_id = asap_q.pop_front(); r.task_valid = 1; r.source = SRC_ASAP;
                end else if (idle_en) begin
                    r.task_id = idle_id; r.task_valid = 1; r.source = SRC_IDLE;
                end
            end
            OP_ASAP: if (asap_q.size() >= ADEP) r.status = ST_FULL; else asap_q.push_back(id);
            OP_IRQ:  if (irq_q.size() >= IDEP) r.status = ST_FULL; else irq_q.push_back(id);
            OP_DEF_AT:  defer_add(id, tv, r);
            OP_DEF_FOR: defer_add(id, now + tv, r);
            OP_REMOVE: begin
                w = 0;
                for (int k = 0; k < dq_used; k++) begin
                    if (dq_task[k] != id) begin
                        dq_time[w] = dq_time[k];
                        dq_task[w] = dq_task[k];
                        w++;
                    end
                end
                if (w == dq_used) r.status = ST_NOT_FOUND;
                dq_used = w;
            end
            OP_PEEK: begin
                if (dq_used > 0) begin
                    r.task_id = dq_task[dq_used-1]; r.task_valid = 1; r.source = SRC_DEFER;
                end else if (asap_q.size() > 0) begin
                    r.task_id = asap_q[0]; r.task_valid = 1; r.source = SRC_ASAP;
                end
            end
            default: dq_used = 0;
        endcase
        r.dcount = dq_used[4:0];
        return r;
    endfunction

    task automatic send_op(t_opcode op, logic [7:0] id, logic [31:0] tv, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_task_id <= id;
        i_time_value <= tv;
        i_now_time <= now;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_dispatch(op, id, tv, now));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDLE_TASK) idle_id = data; else idle_en = data[0];
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_out_task, o_task_valid, t_source'(o_source),
                        t_status'(o_status), o_deferred_count};
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected transaction: actual %p", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t result differs: expected %p actual %p",
                                 $time, exp_r, got);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT) begin
            $display("timed_task_dispatch_queue: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        write_cfg(CFG_IDLE_TASK, 8'hFF);
        write_cfg(CFG_IDLE_ENABLE, 8'h00);
        send_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0);   // nothing runnable, no idle
        send_op(OP_PEEK, 8'h00, 32'h0, 32'h0);
        send_op(OP_REMOVE, 8'h12, 32'h0, 32'h0);      // not found
        for (int k = 0; k < 9; k++) send_op(OP_IRQ, 8'(k * 31), 32'h0, 32'h0); // last is full
        send_op(OP_DEF_AT, 8'hFF, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_DEF_FOR, 8'h00, 32'h10, 32'hFFFF_FFF8);  // wraps
        send_op(OP_DEF_AT, 8'hAA, 32'h8, 32'h0);           // equal time, FIFO order
        send_op(OP_ASAP, 8'h55, 32'h0, 32'h0);
        send_op(OP_PEEK, 8'h00, 32'h0, 32'h0);
        for (int k = 0; k < 10; k++) send_op(OP_DISPATCH, 8'h0, 32'h0, 32'h9);
        write_cfg(CFG_IDLE_ENABLE, 8'h01);
        send_op(OP_DISPATCH, 8'h0, 32'h0, 32'h9);
        send_op(OP_CLEAR, 8'h0, 32'h0, 32'h0);
        send_op(OP_DISPATCH, 8'h0, 32'hFFFF_FFFF, 32'h0);
    endtask

    task automatic test_random(int n);
        t_opcode op;
        logic [7:0] id;
        for (int k = 0; k < n; k++) begin
            clock_now += $urandom_range(3);
            if ($urandom_range(49) == 0) clock_now = $urandom;
            op = t_opcode'($urandom_range(7));
            if (op == OP_CLEAR && $urandom_range(3) != 0) op = OP_DISPATCH;
            id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            if (op == OP_DEF_AT)
                send_op(op, id, ($urandom_range(9) == 0) ? $urandom
                                : clock_now + $urandom_range(40), clock_now);
            else if (op == OP_DEF_FOR)
                send_op(op, id, ($urandom_range(9) == 0) ? $urandom
                                : 32'($urandom_range(40)), clock_now);
            else
                send_op(op, id, $urandom, clock_now);
        end
    endtask

    task automatic test_settings();
        write_cfg(CFG_IDLE_TASK, 8'h00);
        write_cfg(CFG_IDLE_ENABLE, 8'h01);
        send_idle_pct = 11; recv_idle_pct = 84;
        test_random(320);
        wait_drained();   // sender holds off until all results are back
        write_cfg(CFG_IDLE_TASK, 8'($urandom));
        send_idle_pct = 84; recv_idle_pct = 11;
        test_random(300);
        write_cfg(CFG_IDLE_ENABLE, 8'h00);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(310);
    endtask

    initial begin
        dq_used = 0; idle_id = 0; idle_en = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("timed_task_dispatch_queue: match");
        else
            $display("timed_task_dispatch_queue: mismatch");
        $finish;
    end
endmodule
